@@ hw/rtl/fp_multiplier_rne_core_assert.svh @@
// assertion macros for the fp multiplier core
`ifndef FP_MULTIPLIER_RNE_CORE_ASSERT_SVH
`define FP_MULTIPLIER_RNE_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/fpm_pkg.sv @@
package fpm_pkg;
  localparam int ExpBits  = 8;
  localparam int FracBits = 23;
  localparam int SigBits  = 48;

  localparam logic [1:0] ExcZero = 2'd0;
  localparam logic [1:0] ExcNorm = 2'd1;
  localparam logic [1:0] ExcInf  = 2'd2;
  localparam logic [1:0] ExcNan  = 2'd3;

  typedef struct packed {
    logic [1:0]          x_exc;
    logic                x_sign;
    logic [ExpBits-1:0]  x_exp;
    logic [FracBits-1:0] x_frac;
    logic [1:0]          y_exc;
    logic                y_sign;
    logic [ExpBits-1:0]  y_exp;
    logic [FracBits-1:0] y_frac;
  } fpm_in_t;

  typedef struct packed {
    logic [1:0]         r_exc;
    logic               r_sign;
    logic [ExpBits-1:0] r_exp;
    logic [SigBits-1:0] r_sig;
  } fpm_out_t;

  // pipeline flow control shared by the stages
  typedef struct packed {
    logic advance;
  } fpm_ctrl_t;

  function automatic logic [1:0] combine_exc(input logic [1:0] xe, input logic [1:0] ye);
    logic [3:0] sel;
    sel = {xe, ye};
    case (sel)
      4'b0000, 4'b0001, 4'b0100: combine_exc = ExcZero;
      4'b0101:                   combine_exc = ExcNorm;
      4'b0110, 4'b1001, 4'b1010: combine_exc = ExcInf;
      default:                   combine_exc = ExcNan;
    endcase
  endfunction

  function automatic logic [1:0] range_exc(input logic [1:0] top);
    case (top)
      2'b00:   range_exc = ExcNorm;
      2'b01:   range_exc = ExcInf;
      default: range_exc = ExcZero;
    endcase
  endfunction
endpackage

@@ hw/rtl/fpm_round.sv @@
// normalise and round to nearest even (or pass the raw sum and product), registered result
module fpm_round import fpm_pkg::*; (
  input  logic                 clk,
  input  fpm_ctrl_t            ctrl,
  input  logic                 norm,
  input  logic [1:0]           exc,
  input  logic                 sign,
  input  logic [ExpBits+1:0]   exp_sum,
  input  logic [SigBits-1:0]   prod,
  output fpm_out_t             res_r
);
  localparam int P   = 2 * FracBits;
  localparam int Cut = P + 2 - FracBits;

  logic                 top;
  logic [ExpBits+1:0]   e0, e1;
  logic [P+1:0]         ext;
  logic [FracBits:0]    frac;
  logic                 rbit, sticky;
  logic [1:0]           tag;
  fpm_out_t             res_nxt;

  always_comb begin
    top    = prod[P+1];
    e0     = exp_sum + {{(ExpBits+1){1'b0}}, top};
    ext    = top ? {prod[P:0], 1'b0} : {prod[P-1:0], 2'b00};
    rbit   = ext[Cut-1];
    sticky = |ext[Cut-2:0];
    frac   = {1'b0, ext[P+1:Cut]} +
             {{FracBits{1'b0}}, rbit & (sticky | ext[Cut])};
    e1     = e0;
    if (frac[FracBits]) begin
      frac = '0;
      e1   = e0 + {{(ExpBits+1){1'b0}}, 1'b1};
    end
    res_nxt.r_sign = sign;
    if (norm) begin
      tag           = range_exc(e1[ExpBits+1:ExpBits]);
      res_nxt.r_exp = e1[ExpBits-1:0];
      res_nxt.r_sig = {{(SigBits-FracBits){1'b0}}, frac[FracBits-1:0]};
    end else begin
      tag           = range_exc(exp_sum[ExpBits+1:ExpBits]);
      res_nxt.r_exp = exp_sum[ExpBits-1:0];
      res_nxt.r_sig = prod;
    end
    res_nxt.r_exc = (exc != ExcNorm) ? exc : tag;
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) res_r <= res_nxt;
  end
endmodule

@@ hw/rtl/fp_multiplier_rne_core.sv @@
// fp multiplier, tagged format (zero / normal / infinity / nan), round to nearest even
// channels: in_ word (two operands) and out_ word (result), valid/ready each
// cfg_we with cfg_wdata[0] sets the normalise mode (1 rounded, 0 raw sum and product)
// the mode is sampled as a word enters, so change it only while the block is idle
// pipeline of three register stages:
//   s1 operand capture, exponent sum and tag combine
//   s2 24x24 significand product
//   s3 normalise, round, range check (this is the output register)
// throughput: one word per cycle unless out_ready stalls the pipe, set by the single multiplier stage
// a stall on out_ready freezes all stages together, nothing is lost or repeated
// in_ready is low whenever the output word is held, even with bubbles in the pipe
// reset (rst_n low at a clock edge) empties the pipe and selects normalised mode
module fp_multiplier_rne_core import fpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fpm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fpm_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);
`include "fp_multiplier_rne_core_assert.svh"

  localparam logic [ExpBits+1:0] Bias = (ExpBits+2)'((1 << (ExpBits - 1)) - 1);

  logic norm_r;
  logic v1_r, v2_r, v3_r;
  fpm_ctrl_t ctrl;

  // stage 1 payload
  logic               n1_r, s1_r;
  logic [1:0]         exc1_r;
  logic [ExpBits+1:0] es1_r;
  logic [FracBits:0]  mx_r, my_r;
  // stage 2 payload
  logic               n2_r, s2_r;
  logic [1:0]         exc2_r;
  logic [ExpBits+1:0] es2_r;
  logic [SigBits-1:0] p2_r;

  // whole pipe moves when the output slot frees up
  assign ctrl.advance = !v3_r || out_ready;
  assign in_ready     = ctrl.advance;
  assign out_valid    = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b1;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      if (cfg_we) norm_r <= cfg_wdata;
      if (ctrl.advance) begin
        v1_r <= in_valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      n1_r   <= norm_r;
      s1_r   <= in_data.x_sign ^ in_data.y_sign;
      exc1_r <= combine_exc(in_data.x_exc, in_data.y_exc);
      es1_r  <= {2'b00, in_data.x_exp} + {2'b00, in_data.y_exp} - Bias;
      mx_r   <= {1'b1, in_data.x_frac};
      my_r   <= {1'b1, in_data.y_frac};
      n2_r   <= n1_r;
      s2_r   <= s1_r;
      exc2_r <= exc1_r;
      es2_r  <= es1_r;
      p2_r   <= SigBits'(mx_r) * SigBits'(my_r);
    end
  end

  fpm_round u_round (
    .clk     (clk),
    .ctrl    (ctrl),
    .norm    (n2_r),
    .exc     (exc2_r),
    .sign    (s2_r),
    .exp_sum (es2_r),
    .prod    (p2_r),
    .res_r   (out_data)
  );

  // a held result stays put
  `FPM_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // a held output word blocks the input
  `FPM_ASSERT_IMP(a_ready, out_valid && !out_ready, !in_ready)
  // a word in stage two always reaches the output next advance
  `FPM_ASSERT_NXT(a_flow, in_ready && v2_r, out_valid)
  // an empty output slot never blocks the input
  `FPM_ASSERT_IMP(a_empty, !out_valid, in_ready)
endmodule
